[hw/rtl/llta_pkg.sv]
// Shared types and constants for the least-loaded task assigner.
// Used by llta_ctrl, llta_dp and least_loaded_task_assigner.
package llta_pkg;

    localparam int MAX_WORKERS_DEF = 16;
    localparam int LOAD_BITS_DEF   = 40;

    localparam int COST_W = 24;
    localparam int ATOM_W = 12;
    localparam int WIDX_W = 4;
    localparam int CFG_W  = 5;

    localparam logic [CFG_W-1:0] ACTIVE_WORKERS_RST = 5'd16;

    // controller -> datapath
    typedef struct packed {
        logic load_task;   // capture input beat, start a scan
        logic scan_rd;     // read next load entry
        logic finish;      // write back load, present result
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan_last;   // read address is at the last active worker
        logic out_busy;    // result register holds a beat not taken this cycle
    } t_dp_status;

endpackage

[hw/rtl/llta_ctrl.sv]
// Sequencer for the least-loaded task assigner: accept, scan, drain, update.
// Depends on llta_pkg for the command and status structs.
module llta_ctrl
    import llta_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_UPDATE = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state          = r_state;
        o_cmd.load_task  = 1'b0;
        o_cmd.scan_rd    = 1'b0;
        o_cmd.finish     = 1'b0;
        o_s_tready       = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load_task = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            // last read data lands and is compared here
            S_DRAIN: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (!i_status.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[hw/rtl/llta_dp.sv]
// Datapath: load memory with per-entry valid bits, min scan, saturating
// update and result register. Depends on llta_pkg.
module llta_dp
    import llta_pkg::*;
#(
    parameter int MAX_WORKERS = MAX_WORKERS_DEF,
    parameter int LOAD_BITS   = LOAD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_status          o_status,
    input  logic [COST_W-1:0]   i_cost,
    input  logic [ATOM_W-1:0]   i_first_atom,
    input  logic [ATOM_W-1:0]   i_second_atom,
    input  logic                i_new_batch,
    input  logic                i_cfg_wr_en,
    input  logic [CFG_W-1:0]    i_cfg_wr_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [WIDX_W-1:0]   o_worker_index,
    output logic [ATOM_W-1:0]   o_first_atom,
    output logic [ATOM_W-1:0]   o_second_atom,
    output logic                o_load_saturated
);

    localparam int IDX_W   = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int CNT_RAW = $clog2(MAX_WORKERS + 1);
    localparam int CNT_W   = (CNT_RAW > CFG_W) ? CNT_RAW : CFG_W;
    localparam int SUM_W   = ((LOAD_BITS > COST_W) ? LOAD_BITS : COST_W) + 1;

    logic [LOAD_BITS-1:0]   mem [MAX_WORKERS];
    logic [MAX_WORKERS-1:0] r_valid;

    logic [CFG_W-1:0]     r_active_workers;
    logic [COST_W-1:0]    r_cost;
    logic [ATOM_W-1:0]    r_first_atom;
    logic [ATOM_W-1:0]    r_second_atom;
    logic [IDX_W-1:0]     r_addr;
    logic [IDX_W-1:0]     r_last_idx;
    logic                 r_rd_vld;
    logic                 r_rd_ok;
    logic [IDX_W-1:0]     r_rd_idx;
    logic [LOAD_BITS-1:0] r_rd_data;
    logic [LOAD_BITS-1:0] r_best_load;
    logic [IDX_W-1:0]     r_best_idx;
    logic                 r_out_valid;
    logic [WIDX_W-1:0]    r_out_widx;
    logic [ATOM_W-1:0]    r_out_a1;
    logic [ATOM_W-1:0]    r_out_a2;
    logic                 r_out_sat;

    logic [CNT_W-1:0]     cfg_ext;
    logic [CNT_W-1:0]     eff_cnt;
    logic [CNT_W-1:0]     eff_last;
    logic [LOAD_BITS-1:0] rd_load;
    logic [SUM_W-1:0]     sum;
    logic                 ovf;
    logic [LOAD_BITS-1:0] new_load;
    logic [IDX_W+WIDX_W-1:0] widx_ext;

    // zero acts as one, anything above the worker count is clamped
    always_comb begin
        cfg_ext = CNT_W'(r_active_workers);
        eff_cnt = cfg_ext;
        if (cfg_ext == '0) begin
            eff_cnt = CNT_W'(1);
        end else if (cfg_ext > CNT_W'(MAX_WORKERS)) begin
            eff_cnt = CNT_W'(MAX_WORKERS);
        end
        eff_last = eff_cnt - CNT_W'(1);
    end

    assign rd_load  = r_rd_ok ? r_rd_data : '0;
    assign sum      = SUM_W'(r_best_load) + SUM_W'(r_cost);
    assign ovf      = (sum[SUM_W-1:LOAD_BITS] != '0);
    assign new_load = ovf ? '1 : sum[LOAD_BITS-1:0];
    assign widx_ext = {{WIDX_W{1'b0}}, r_best_idx};

    assign o_status.scan_last = (r_addr == r_last_idx);
    assign o_status.out_busy  = r_out_valid && !i_out_ready;

    // load storage, no reset: r_valid masks stale entries
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            mem[r_best_idx] <= new_load;
        end
        if (i_cmd.scan_rd) begin
            r_rd_data <= mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_workers <= ACTIVE_WORKERS_RST;
            r_valid          <= '0;
            r_rd_vld         <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_active_workers <= i_cfg_wr_data;
            end
            r_rd_vld <= i_cmd.scan_rd;
            if (i_cmd.load_task && i_new_batch) begin
                r_valid <= '0;
            end else if (i_cmd.finish) begin
                r_valid[r_best_idx] <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_task) begin
            r_cost        <= i_cost;
            r_first_atom  <= i_first_atom;
            r_second_atom <= i_second_atom;
            r_addr        <= '0;
            r_last_idx    <= eff_last[IDX_W-1:0];
        end else if (i_cmd.scan_rd) begin
            r_addr <= r_addr + IDX_W'(1);
        end
        if (i_cmd.scan_rd) begin
            r_rd_ok  <= r_valid[r_addr];
            r_rd_idx <= r_addr;
        end
        // strict less-than keeps the lowest index on a tie
        if (r_rd_vld && ((r_rd_idx == '0) || (rd_load < r_best_load))) begin
            r_best_load <= rd_load;
            r_best_idx  <= r_rd_idx;
        end
        if (i_cmd.finish) begin
            r_out_widx <= widx_ext[WIDX_W-1:0];
            r_out_a1   <= r_first_atom;
            r_out_a2   <= r_second_atom;
            r_out_sat  <= (new_load == '1);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_worker_index   = r_out_widx;
    assign o_first_atom     = r_out_a1;
    assign o_second_atom    = r_out_a2;
    assign o_load_saturated = r_out_sat;

endmodule

[hw/rtl/least_loaded_task_assigner.sv]
// Least-loaded task assigner: each task beat goes to the active worker with
// the smallest accumulated load (lowest index on a tie); the cost is added to
// that load, clamped at the largest LOAD_BITS value. A set tuser bit on the
// input beat clears all loads first. One task is handled at a time: the beat is
// accepted, the load memory is read once per active worker during the minimum
// scan, the last read is compared and the saturating update follows. The
// result sits in an output register, so the next task is accepted while the
// previous result waits; the update cycle holds for as long as a previous
// result beat is still not taken. Reset needs no clearing pass; loads are
// masked by per-worker valid bits.
// Depends on llta_pkg, llta_ctrl and llta_dp.
module least_loaded_task_assigner
    import llta_pkg::*;
#(
    parameter int MAX_WORKERS = MAX_WORKERS_DEF,
    parameter int LOAD_BITS   = LOAD_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    // [23:0] task_cost, [35:24] first_atom, [47:36] second_atom
    input  logic [47:0]       i_s_tdata,
    // [0] new_batch
    input  logic              i_s_tuser,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    // [3:0] worker_index, [15:4] out_first_atom, [27:16] out_second_atom,
    // [31:28] zero
    output logic [31:0]       o_m_tdata,
    // [0] load_saturated
    output logic              o_m_tuser,
    input  logic              i_cfg_wr_en,
    input  logic [CFG_W-1:0]  i_cfg_wr_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    logic [WIDX_W-1:0] worker_index;
    logic [ATOM_W-1:0] out_first_atom;
    logic [ATOM_W-1:0] out_second_atom;

    llta_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    llta_dp #(
        .MAX_WORKERS (MAX_WORKERS),
        .LOAD_BITS   (LOAD_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_cost           (i_s_tdata[23:0]),
        .i_first_atom     (i_s_tdata[35:24]),
        .i_second_atom    (i_s_tdata[47:36]),
        .i_new_batch      (i_s_tuser),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .o_out_valid      (o_m_tvalid),
        .i_out_ready      (i_m_tready),
        .o_worker_index   (worker_index),
        .o_first_atom     (out_first_atom),
        .o_second_atom    (out_second_atom),
        .o_load_saturated (o_m_tuser)
    );

    assign o_m_tdata = {4'b0000, out_second_atom, out_first_atom, worker_index};

endmodule
